### hdl/submatrix_matrix_product_assert.svh
// Assertion macros for the top RTL file of the sub-block matrix product.
`ifndef SUBMATRIX_MATRIX_PRODUCT_ASSERT_SVH
`define SUBMATRIX_MATRIX_PRODUCT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SMM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/smm_pkg.sv
`timescale 1ns / 1ps

package smm_pkg;

    // Port widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;

    // Field widths
    localparam int POS_W = 3;
    localparam int CNT_W = 4;
    localparam int VAL_W = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W = 68;

    // Request kinds
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROW_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COL_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COL_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROD_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROD_COLS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT = 3'd6;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ROUND,
        ST_SEND
    } state_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic term_vld;
    } mac_ctrl_t;

endpackage

### hdl/smm_ram.sv
`timescale 1ns / 1ps

module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### hdl/smm_mac.sv
`timescale 1ns / 1ps

module smm_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  smm_pkg::mac_ctrl_t                ctrl,
    input  logic signed [smm_pkg::VAL_W-1:0]  a_data,
    input  logic signed [smm_pkg::VAL_W-1:0]  b_data,
    output logic                              busy,
    output logic signed [smm_pkg::VAL_W-1:0]  result
);

    import smm_pkg::*;

    localparam int RND_LSB = 16;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic                     fits;

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.term_vld;
        end
        prod_reg <= a_data * b_data;
    end

    // Accumulate stage, exact sum of Q32.32 terms
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign busy = prod_vld_reg;

    // Round half up to Q16.16, then saturate to 32 bits
    always_comb begin
        acc_rnd = acc_reg + ACC_W'(1 << (RND_LSB - 1));
        fits = (&acc_rnd[ACC_W-1:RND_LSB+VAL_W-1]) || !(|acc_rnd[ACC_W-1:RND_LSB+VAL_W-1]);
        if (fits) begin
            result = acc_rnd[RND_LSB+VAL_W-1:RND_LSB];
        end else if (acc_rnd[ACC_W-1]) begin
            result = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

endmodule

### hdl/submatrix_matrix_product.sv
`timescale 1ns / 1ps
// Sub-block matrix product. Load beats (s_tuser kind 0 or 1) write one Q16.16 element of
// store A or B; a load outside the DIM x DIM store is dropped and
// kind 3 is ignored. A compute beat (kind 2) multiplies the configured A sub-block by the
// B sub-block and returns one entry per product row and column in row-major order, the
// final one with m_tlast set. Entries are summed exactly, rounded half up and saturated.
// If a block leaves the store or a count is zero, a single beat with m_tuser set comes out
// instead. One multiplier, fed from one read port per store, serves every term, and the
// block accepts nothing while a compute runs. Only entries already loaded may be read by a
// compute. Write the configuration only while the block is idle.

`include "submatrix_matrix_product_assert.svh"

module submatrix_matrix_product #(
    parameter int DIM = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: elem_row[2:0], elem_col[5:3], elem_value[37:6], zero pad[39:38]
    input  logic [smm_pkg::S_TDATA_W-1:0]         s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [smm_pkg::S_TUSER_W-1:0]         s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: out_row[2:0], out_col[5:3], out_value[37:6], zero pad[39:38]
    output logic [smm_pkg::M_TDATA_W-1:0]         m_tdata,
    // m_tuser: range_error[0]
    output logic [smm_pkg::M_TUSER_W-1:0]         m_tuser,
    output logic                                  m_tlast,
    // Configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [smm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [smm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    import smm_pkg::*;

    localparam int DEPTH = DIM * DIM;
    localparam int AW = $clog2(DEPTH);
    localparam int SUM_W = CNT_W + 1;

    // Configuration registers
    logic [POS_W-1:0] a_row_start_reg, a_col_start_reg, b_row_start_reg, b_col_start_reg;
    logic [CNT_W-1:0] prod_rows_reg, prod_cols_reg, inner_count_reg;

    state_t state_reg, state_next;
    logic [POS_W-1:0] r_reg, r_next, c_reg, c_next, m_reg, m_next;
    logic             rd_vld_reg;

    logic [POS_W-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next, out_err_reg, out_err_next;

    // Input beat fields
    logic [1:0]       req_type;
    logic [POS_W-1:0] elem_row, elem_col;
    logic [VAL_W-1:0] elem_value;

    logic             in_beat, out_beat, load_ok, block_err;
    logic             term_last, col_last, row_last, issue;
    logic [CNT_W-1:0] a_row, a_col, b_row, b_col;
    logic [AW-1:0]    wr_addr, a_rd_addr, b_rd_addr;
    logic [VAL_W-1:0] a_rd_data, b_rd_data;
    logic             a_wr_en, b_wr_en;
    logic signed [VAL_W-1:0] mac_result;
    logic             mac_busy;
    mac_ctrl_t        mac_ctrl;

    assign req_type = s_tuser[1:0];
    assign elem_row = s_tdata[2:0];
    assign elem_col = s_tdata[5:3];
    assign elem_value = s_tdata[37:6];

    assign in_beat = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Write configuration registers, ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_row_start_reg <= '0;
            a_col_start_reg <= '0;
            b_row_start_reg <= '0;
            b_col_start_reg <= '0;
            prod_rows_reg <= CNT_W'(8);
            prod_cols_reg <= CNT_W'(8);
            inner_count_reg <= CNT_W'(8);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_A_ROW_START: a_row_start_reg <= cfg_wdata[POS_W-1:0];
                CFG_A_COL_START: a_col_start_reg <= cfg_wdata[POS_W-1:0];
                CFG_B_ROW_START: b_row_start_reg <= cfg_wdata[POS_W-1:0];
                CFG_B_COL_START: b_col_start_reg <= cfg_wdata[POS_W-1:0];
                CFG_PROD_ROWS:   prod_rows_reg <= cfg_wdata;
                CFG_PROD_COLS:   prod_cols_reg <= cfg_wdata;
                CFG_INNER_COUNT: inner_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Flag a zero count or a sub-block that leaves the store
    always_comb begin
        block_err = (prod_rows_reg == '0) || (prod_cols_reg == '0) || (inner_count_reg == '0)
            || (SUM_W'(a_row_start_reg) + SUM_W'(prod_rows_reg) > SUM_W'(DIM))
            || (SUM_W'(a_col_start_reg) + SUM_W'(inner_count_reg) > SUM_W'(DIM))
            || (SUM_W'(b_row_start_reg) + SUM_W'(inner_count_reg) > SUM_W'(DIM))
            || (SUM_W'(b_col_start_reg) + SUM_W'(prod_cols_reg) > SUM_W'(DIM));
    end

    // Loop ends
    assign term_last = (CNT_W'(m_reg) + CNT_W'(1)) == inner_count_reg;
    assign col_last = (CNT_W'(c_reg) + CNT_W'(1)) == prod_cols_reg;
    assign row_last = (CNT_W'(r_reg) + CNT_W'(1)) == prod_rows_reg;

    // Store addresses
    always_comb begin
        a_row = CNT_W'(a_row_start_reg) + CNT_W'(r_reg);
        a_col = CNT_W'(a_col_start_reg) + CNT_W'(m_reg);
        b_row = CNT_W'(b_row_start_reg) + CNT_W'(m_reg);
        b_col = CNT_W'(b_col_start_reg) + CNT_W'(c_reg);
        a_rd_addr = AW'(a_row * DIM + a_col);
        b_rd_addr = AW'(b_row * DIM + b_col);
        wr_addr = AW'(elem_row * DIM + elem_col);
        load_ok = (CNT_W'(elem_row) < CNT_W'(DIM)) && (CNT_W'(elem_col) < CNT_W'(DIM));
    end

    assign a_wr_en = in_beat && (req_type == REQ_LOAD_A) && load_ok;
    assign b_wr_en = in_beat && (req_type == REQ_LOAD_B) && load_ok;

    smm_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_store_a (
        .aclk   (aclk),
        .wr_en  (a_wr_en),
        .wr_addr(wr_addr),
        .wr_data(elem_value),
        .rd_en  (issue),
        .rd_addr(a_rd_addr),
        .rd_data(a_rd_data)
    );

    smm_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_store_b (
        .aclk   (aclk),
        .wr_en  (b_wr_en),
        .wr_addr(wr_addr),
        .wr_data(elem_value),
        .rd_en  (issue),
        .rd_addr(b_rd_addr),
        .rd_data(b_rd_data)
    );

    smm_mac u_mac (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (mac_ctrl),
        .a_data (a_rd_data),
        .b_data (b_rd_data),
        .busy   (mac_busy),
        .result (mac_result)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && (req_type == REQ_COMPUTE)) begin
                    state_next = block_err ? ST_SEND : ST_RUN;
                end
            end
            ST_RUN: begin
                if (term_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mac_busy) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = ST_SEND;
            ST_SEND: begin
                if (out_beat) begin
                    state_next = out_last_reg ? ST_IDLE : ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and unit control
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_SEND);
        issue = (state_reg == ST_RUN);
        mac_ctrl.clear = issue && (m_reg == '0);
        mac_ctrl.term_vld = rd_vld_reg;
    end

    // Advance counters and load the result register
    always_comb begin
        r_next = r_reg;
        c_next = c_reg;
        m_next = m_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        out_value_next = out_value_reg;
        out_last_next = out_last_reg;
        out_err_next = out_err_reg;
        case (state_reg)
            ST_IDLE: begin
                r_next = '0;
                c_next = '0;
                m_next = '0;
                if (in_beat && (req_type == REQ_COMPUTE) && block_err) begin
                    out_row_next = '0;
                    out_col_next = '0;
                    out_value_next = '0;
                    out_last_next = 1'b1;
                    out_err_next = 1'b1;
                end
            end
            ST_RUN: begin
                m_next = term_last ? '0 : m_reg + POS_W'(1);
            end
            ST_ROUND: begin
                out_row_next = r_reg;
                out_col_next = c_reg;
                out_value_next = mac_result;
                out_last_next = row_last && col_last;
                out_err_next = 1'b0;
            end
            ST_SEND: begin
                if (out_beat && !out_last_reg) begin
                    if (col_last) begin
                        c_next = '0;
                        r_next = r_reg + POS_W'(1);
                    end else begin
                        c_next = c_reg + POS_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            r_reg <= '0;
            c_reg <= '0;
            m_reg <= '0;
        end else begin
            state_reg <= state_next;
            rd_vld_reg <= issue;
            r_reg <= r_next;
            c_reg <= c_next;
            m_reg <= m_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        out_value_reg <= out_value_next;
        out_last_reg <= out_last_next;
        out_err_reg <= out_err_next;
    end

    assign m_tdata = {{(M_TDATA_W-2*POS_W-VAL_W){1'b0}}, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser = out_err_reg;
    assign m_tlast = out_last_reg;

    // Checks
    `SMM_ASSERT(a_no_accept_while_sending, m_tvalid |-> !s_tready,
        "input accepted while a result is pending")
    `SMM_ASSERT(a_error_is_sole, (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata[37:6] == '0),
        "range error beat is not a lone zero beat")
    `SMM_ASSERT(a_read_follows_issue, rd_vld_reg |-> ($past(state_reg) == ST_RUN),
        "store data marked valid without a read")
    `SMM_ASSERT(a_round_after_drain, (state_reg == ST_ROUND) |-> (!rd_vld_reg && !mac_busy),
        "result rounded while terms are still in flight")
    `SMM_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_tvalid),
        "sequencer not idle after reset")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import smm_pkg::*;

    localparam int MAT_DIM = 8;
    localparam int IDLE_PCT = 21;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT = 3000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
        logic        err;
    } entry_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow stores and register file of the block
    logic [31:0] mat_a [MAT_DIM][MAT_DIM];
    logic [31:0] mat_b [MAT_DIM][MAT_DIM];
    logic [3:0]  cfg_regs [7];
    // Entries that the stimulus has already queued a load for
    bit          loaded_a [MAT_DIM][MAT_DIM];
    bit          loaded_b [MAT_DIM][MAT_DIM];

    request_t request_queue[$];
    entry_t   pending_entries[$];
    request_t drive_req;
    entry_t   seen_entry;
    entry_t   want_entry;
    int       fail_count = 0;
    int       stall_cycles = 0;
    bit       calm = 1'b0;
    bit       beat_taken = 1'b0;

    submatrix_matrix_product #(
        .DIM(MAT_DIM)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Check the configured sub-blocks against the store bounds
    function automatic bit setup_in_range();
        int ar, ac, br, bc, nr, nc, ni;
        ar = cfg_regs[CFG_A_ROW_START];
        ac = cfg_regs[CFG_A_COL_START];
        br = cfg_regs[CFG_B_ROW_START];
        bc = cfg_regs[CFG_B_COL_START];
        nr = cfg_regs[CFG_PROD_ROWS];
        nc = cfg_regs[CFG_PROD_COLS];
        ni = cfg_regs[CFG_INNER_COUNT];
        return nr != 0 && nc != 0 && ni != 0 && ar + nr <= MAT_DIM && ac + ni <= MAT_DIM
            && br + ni <= MAT_DIM && bc + nc <= MAT_DIM;
    endfunction

    // Exact dot product in a wide accumulator, rounded half up, saturated to 32 bits
    function automatic logic [31:0] sub_block_entry(input int r, input int c);
        logic signed [67:0] acc;
        logic signed [67:0] rounded;
        longint             term;
        int                 ar, ac, br, bc;
        ar = cfg_regs[CFG_A_ROW_START];
        ac = cfg_regs[CFG_A_COL_START];
        br = cfg_regs[CFG_B_ROW_START];
        bc = cfg_regs[CFG_B_COL_START];
        acc = '0;
        for (int m = 0; m < int'(cfg_regs[CFG_INNER_COUNT]); m++) begin
            term = longint'($signed(mat_a[ar + r][ac + m]))
                 * longint'($signed(mat_b[br + m][bc + c]));
            acc = acc + term;
        end
        rounded = (acc + 68'sd32768) >>> 16;
        if (rounded > 68'sd2147483647)
            return 32'h7FFFFFFF;
        if (rounded < -68'sd2147483648)
            return 32'h80000000;
        return rounded[31:0];
    endfunction

    // Queue the expected entries of one compute beat
    function automatic void predict_product();
        entry_t e;
        int     nr, nc;
        nr = cfg_regs[CFG_PROD_ROWS];
        nc = cfg_regs[CFG_PROD_COLS];
        if (!setup_in_range()) begin
            e = '{row: 3'd0, col: 3'd0, value: 32'd0, last: 1'b1, err: 1'b1};
            pending_entries.push_back(e);
            return;
        end
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                e.row = r[2:0];
                e.col = c[2:0];
                e.value = sub_block_entry(r, c);
                e.last = (r == nr - 1) && (c == nc - 1);
                e.err = 1'b0;
                pending_entries.push_back(e);
            end
        end
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: begin
                v = $urandom_range(0, 32'h3FFFF);
                return v - 32'h20000;
            end
            1: begin
                case ($urandom_range(4))
                    0: return 32'h80000000;
                    1: return 32'h7FFFFFFF;
                    2: return 32'h00000000;
                    3: return 32'hFFFFFFFF;
                    default: return 32'h00008000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_load(input logic [1:0] kind, input logic [2:0] row,
                              input logic [2:0] col, input logic [31:0] value);
        if (kind == REQ_LOAD_A)
            loaded_a[row][col] = 1'b1;
        else
            loaded_b[row][col] = 1'b1;
        request_queue.push_back({kind, row, col, value});
    endtask

    // Load any entry of the configured blocks not yet written, then queue the compute
    task automatic queue_compute();
        int ar, ac, br, bc;
        ar = cfg_regs[CFG_A_ROW_START];
        ac = cfg_regs[CFG_A_COL_START];
        br = cfg_regs[CFG_B_ROW_START];
        bc = cfg_regs[CFG_B_COL_START];
        if (setup_in_range()) begin
            for (int r = ar; r < ar + cfg_regs[CFG_PROD_ROWS]; r++)
                for (int c = ac; c < ac + cfg_regs[CFG_INNER_COUNT]; c++)
                    if (!loaded_a[r][c])
                        queue_load(REQ_LOAD_A, r[2:0], c[2:0], random_value());
            for (int r = br; r < br + cfg_regs[CFG_INNER_COUNT]; r++)
                for (int c = bc; c < bc + cfg_regs[CFG_PROD_COLS]; c++)
                    if (!loaded_b[r][c])
                        queue_load(REQ_LOAD_B, r[2:0], c[2:0], random_value());
        end
        request_queue.push_back({REQ_COMPUTE, 3'($urandom()), 3'($urandom()), 32'($urandom())});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= CFG_INNER_COUNT)
            cfg_regs[idx] = (idx < CFG_PROD_ROWS) ? (val & 4'h7) : val;
    endtask

    task automatic set_config(input logic [3:0] ar, input logic [3:0] ac, input logic [3:0] br,
                              input logic [3:0] bc, input logic [3:0] nr, input logic [3:0] nc,
                              input logic [3:0] ni);
        write_reg(CFG_A_ROW_START, ar);
        write_reg(CFG_A_COL_START, ac);
        write_reg(CFG_B_ROW_START, br);
        write_reg(CFG_B_COL_START, bc);
        write_reg(CFG_PROD_ROWS, nr);
        write_reg(CFG_PROD_COLS, nc);
        write_reg(CFG_INNER_COUNT, ni);
    endtask

    // Hold until every beat is sent and every entry is back, then let the block settle
    task automatic wait_idle();
        while (request_queue.size() != 0 || s_tvalid || pending_entries.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One compute alone when n_items is zero, else a random mix of beats
    task automatic run_phase(input logic [3:0] ar, input logic [3:0] ac, input logic [3:0] br,
                             input logic [3:0] bc, input logic [3:0] nr, input logic [3:0] nc,
                             input logic [3:0] ni, input int n_items);
        int roll;
        set_config(ar, ac, br, bc, nr, nc, ni);
        if (n_items == 0)
            queue_compute();
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (roll < 5)
                request_queue.push_back({REQ_UNUSED, 3'($urandom()), 3'($urandom()),
                                         random_value()});
            else if (roll < 30)
                queue_compute();
            else
                queue_load($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A,
                           3'($urandom_range(7)), 3'($urandom_range(7)), random_value());
        end
        wait_idle();
    endtask

    // Drive input beats and result backpressure on the falling edge
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || beat_taken)) begin
            if (request_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                drive_req = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {2'b00, drive_req.value, drive_req.col, drive_req.row};
                s_tuser <= drive_req.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Update the shadow stores and predict on each accepted input beat
    always @(posedge aclk) begin
        beat_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            case (s_tuser)
                REQ_LOAD_A: mat_a[s_tdata[2:0]][s_tdata[5:3]] = s_tdata[37:6];
                REQ_LOAD_B: mat_b[s_tdata[2:0]][s_tdata[5:3]] = s_tdata[37:6];
                REQ_COMPUTE: predict_product();
                default: ;
            endcase
        end
    end

    // Compare each result beat against the oldest expected entry
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_entry = {m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast, m_tuser[0]};
            if (pending_entries.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat: row %0d col %0d value %h",
                                          seen_entry.row, seen_entry.col, seen_entry.value));
            end else begin
                want_entry = pending_entries.pop_front();
                if (seen_entry.row !== want_entry.row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              seen_entry.row, want_entry.row));
                if (seen_entry.col !== want_entry.col)
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              seen_entry.col, want_entry.col));
                if (seen_entry.value !== want_entry.value)
                    report_mismatch($sformatf("out_value %h, expected %h (row %0d col %0d)",
                                              seen_entry.value, want_entry.value,
                                              want_entry.row, want_entry.col));
                if (seen_entry.last !== want_entry.last)
                    report_mismatch($sformatf("m_tlast %b, expected %b",
                                              seen_entry.last, want_entry.last));
                if (seen_entry.err !== want_entry.err)
                    report_mismatch($sformatf("range_error %b, expected %b",
                                              seen_entry.err, want_entry.err));
            end
        end
    end

    // Abort when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int nr, nc, ni;
        for (int i = 0; i < 7; i++)
            cfg_regs[i] = (i >= CFG_PROD_ROWS) ? 4'd8 : 4'd0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Saturation at both ends: a 1 x 2 product summed over two terms
        set_config(4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd2);
        queue_load(REQ_LOAD_A, 3'd0, 3'd0, 32'h80000000);
        queue_load(REQ_LOAD_A, 3'd0, 3'd1, 32'h80000000);
        queue_load(REQ_LOAD_B, 3'd0, 3'd0, 32'h80000000);
        queue_load(REQ_LOAD_B, 3'd1, 3'd0, 32'h80000000);
        queue_load(REQ_LOAD_B, 3'd0, 3'd1, 32'h7FFFFFFF);
        queue_load(REQ_LOAD_B, 3'd1, 3'd1, 32'h7FFFFFFF);
        request_queue.push_back({REQ_UNUSED, 3'd7, 3'd7, 32'hFFFFFFFF});
        queue_compute();
        // Rounding of exact halves, positive and negative
        queue_load(REQ_LOAD_A, 3'd0, 3'd0, 32'h00000001);
        queue_load(REQ_LOAD_A, 3'd0, 3'd1, 32'h00000000);
        queue_load(REQ_LOAD_B, 3'd0, 3'd0, 32'h00008000);
        queue_load(REQ_LOAD_B, 3'd1, 3'd0, 32'h00001234);
        queue_load(REQ_LOAD_B, 3'd0, 3'd1, 32'hFFFF8000);
        queue_load(REQ_LOAD_B, 3'd1, 3'd1, 32'h00000005);
        queue_compute();
        queue_load(REQ_LOAD_A, 3'd7, 3'd7, 32'h7FFFFFFF);
        queue_load(REQ_LOAD_B, 3'd7, 3'd7, 32'hFFFFFFFF);
        wait_idle();

        // Unmapped register index must leave the setup alone
        write_reg(CFG_UNMAPPED, 4'($urandom_range(15)));

        // Zero counts and blocks running past the store
        run_phase(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 0);
        run_phase(4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd1, 0);
        run_phase(4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd0, 0);
        run_phase(4'd15, 4'd0, 4'd0, 4'd0, 4'd2, 4'd1, 4'd1, 0);
        run_phase(4'd0, 4'd7, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 0);
        run_phase(4'd0, 4'd0, 4'd7, 4'd0, 4'd1, 4'd1, 4'd2, 0);
        run_phase(4'd0, 4'd0, 4'd0, 4'd7, 4'd1, 4'd2, 4'd1, 0);
        run_phase(4'd0, 4'd0, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15, 0);

        // Corner element alone, then a full-size 8 x 8 product
        run_phase(4'd7, 4'd7, 4'd7, 4'd7, 4'd1, 4'd1, 4'd1, 6);
        run_phase(4'd0, 4'd0, 4'd0, 4'd0, 4'd8, 4'd8, 4'd1, 8);

        // Random in-range setups, mostly small
        for (int i = 0; i < 4; i++) begin
            nr = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
            nc = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
            ni = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
            calm = (i == 2);
            run_phase(4'($urandom_range(MAT_DIM - nr)), 4'($urandom_range(MAT_DIM - ni)),
                      4'($urandom_range(MAT_DIM - ni)), 4'($urandom_range(MAT_DIM - nc)),
                      4'(nr), 4'(nc), 4'(ni), 8);
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
